>>> hdl/obb_closest_point_assert.svh
// Assertion macros for the oriented box closest point block.
`ifndef OBB_CLOSEST_POINT_ASSERT_SVH
`define OBB_CLOSEST_POINT_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define OBB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("obb_closest_point: assertion failed");
// Next-cycle implication, disabled during reset.
`define OBB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("obb_closest_point: assertion failed");
`endif

>>> hdl/obb_pkg.sv
// Shared types, codes and the CORDIC arctangent table.
package obb_pkg;

  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_HALF_WIDTH  = 3'd2,
    REG_HALF_HEIGHT = 3'd3,
    REG_BOX_ANGLE   = 3'd4
  } obb_reg_t;

  typedef enum logic [1:0] {
    TRIG_IDLE,
    TRIG_ROTATE,
    TRIG_FINISH
  } obb_trig_state_t;

  typedef struct packed {
    logic empty;
    logic full;
  } obb_q_status_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int TABLE_LEN = 24;
  // CORDIC gain in Q2.30
  localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;

  // Rounded arctangent of 2^-i, 2^32 per turn.
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/obb_closest_point.sv
// Top level: closest point on one configured oriented 2D box.
// One query point is taken per clock cycle whenever busy is low, and its
// result appears with done in order; the receiver must take every result
// in the cycle it is shown. Each query passes a front register, the
// two-entry queue and a six-stage back end with two rounds of four
// multipliers. Writing box_angle runs a CORDIC through ROTATION_STEPS
// iterations and a load step, and busy is high while it runs. busy is also
// high during reset.
module obb_closest_point import obb_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int FRACTION_BITS = 16,
  parameter int ROTATION_STEPS = 16,
  parameter int DATA_BITS = (COORD_BITS > 32) ? 64 : 32,
  parameter int ADDR_BITS = (DATA_BITS == 64) ? 6 : 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  output logic                         done,
  output logic signed [COORD_BITS-1:0] near_x,
  output logic signed [COORD_BITS-1:0] near_y,
  output logic                         is_inside,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_BITS-1:0]         paddr,
  input  logic [DATA_BITS-1:0]         pwdata,
  output logic [DATA_BITS-1:0]         prdata,
  output logic                         pready
);
  localparam int AL = ADDR_BITS - 3;
  localparam int EW = 4 * COORD_BITS + 2;

  logic signed [COORD_BITS-1:0] center_x, center_y;
  logic [COORD_BITS-2:0] half_width, half_height;
  logic [15:0] box_angle;
  logic signed [FRACTION_BITS+1:0] cosine_value, sine_value;
  logic wr, trig_busy, take, push;
  obb_reg_t idx;
  logic [EW-1:0] entry, q_data;
  obb_q_status_t q_status;

  assign pready = 1'b1;
  assign idx = obb_reg_t'(paddr[ADDR_BITS-1:AL]);
  assign wr = psel && penable && pwrite;
  assign busy = rst || trig_busy || q_status.full;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      half_width <= '0;
      half_height <= '0;
      box_angle <= '0;
    end else if (wr) begin
      case (idx)
        REG_CENTER_X:    center_x <= pwdata[COORD_BITS-1:0];
        REG_CENTER_Y:    center_y <= pwdata[COORD_BITS-1:0];
        REG_HALF_WIDTH:  half_width <= pwdata[COORD_BITS-2:0];
        REG_HALF_HEIGHT: half_height <= pwdata[COORD_BITS-2:0];
        REG_BOX_ANGLE:   box_angle <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CENTER_X:    prdata = DATA_BITS'(center_x);
      REG_CENTER_Y:    prdata = DATA_BITS'(center_y);
      REG_HALF_WIDTH:  prdata = DATA_BITS'(half_width);
      REG_HALF_HEIGHT: prdata = DATA_BITS'(half_height);
      REG_BOX_ANGLE:   prdata = DATA_BITS'(box_angle);
      default:         prdata = '0;
    endcase
  end

  obb_cordic #(.FRACTION_BITS(FRACTION_BITS), .ROTATION_STEPS(ROTATION_STEPS)) u_cordic (
    .clk(clk), .rst(rst),
    .go(wr && idx == REG_BOX_ANGLE),
    .angle(pwdata[15:0]),
    .busy(trig_busy),
    .cosine_value(cosine_value), .sine_value(sine_value)
  );

  obb_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .take(take),
    .query_x(query_x), .query_y(query_y),
    .center_x(center_x), .center_y(center_y),
    .push(push), .entry(entry)
  );

  obb_queue #(.WIDTH(EW)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(entry),
    .pop(1'b1), .rdata(q_data), .status(q_status)
  );

  obb_back #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst),
    .in_valid(!q_status.empty), .entry(q_data),
    .cosine_value(cosine_value), .sine_value(sine_value),
    .center_x(center_x), .center_y(center_y),
    .half_width(half_width), .half_height(half_height),
    .done(done), .near_x(near_x), .near_y(near_y), .is_inside(is_inside)
  );
endmodule

>>> hdl/obb_cordic.sv
// Iterative CORDIC that turns the box angle into cosine and sine.
module obb_cordic import obb_pkg::*; #(
  parameter int FRACTION_BITS = 16,
  parameter int ROTATION_STEPS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [15:0]                     angle,
  output logic                            busy,
  output logic signed [FRACTION_BITS+1:0] cosine_value,
  output logic signed [FRACTION_BITS+1:0] sine_value
);
  localparam int TW = FRACTION_BITS + 2;
  localparam int XW = 34;
  localparam int SH = 30 - FRACTION_BITS;
  localparam int STEP_BITS = $clog2(ROTATION_STEPS);
  localparam logic signed [XW-1:0] RND = XW'(1) << (SH - 1);
  localparam logic signed [XW-1:0] ONE = XW'(1) << FRACTION_BITS;

  obb_trig_state_t state, state_next;
  logic [STEP_BITS-1:0] step;
  logic [1:0] quad;
  logic signed [XW-1:0] x, y, z;
  logic signed [XW-1:0] xs, ys, atn, rx, ry, cx, cy;
  logic signed [TW-1:0] c, s;
  logic rotating, loading;

  always_comb begin
    state_next = state;
    case (state)
      TRIG_IDLE:   if (go) state_next = TRIG_ROTATE;
      TRIG_ROTATE: if (step == STEP_BITS'(ROTATION_STEPS - 1)) state_next = TRIG_FINISH;
      TRIG_FINISH: state_next = TRIG_IDLE;
      default:     state_next = TRIG_IDLE;
    endcase
  end

  always_comb begin
    rotating = 1'b0;
    loading = 1'b0;
    busy = 1'b1;
    case (state)
      TRIG_IDLE:   busy = 1'b0;
      TRIG_ROTATE: rotating = 1'b1;
      TRIG_FINISH: loading = 1'b1;
      default:     busy = 1'b0;
    endcase
  end

  always_comb begin
    xs = x >>> step;
    ys = y >>> step;
    atn = signed'({2'b00, atan_turns(5'(step))});
    rx = (x + RND) >>> SH;
    ry = (y + RND) >>> SH;
    cx = (rx > ONE) ? ONE : ((rx < -ONE) ? -ONE : rx);
    cy = (ry > ONE) ? ONE : ((ry < -ONE) ? -ONE : ry);
    c = cx[TW-1:0];
    s = cy[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TRIG_IDLE;
      cosine_value <= TW'(1) << FRACTION_BITS;
      sine_value <= '0;
    end else begin
      state <= state_next;
      if (loading) begin
        case (quad)
          2'd0: begin cosine_value <= c;  sine_value <= s;  end
          2'd1: begin cosine_value <= -s; sine_value <= c;  end
          2'd2: begin cosine_value <= -c; sine_value <= -s; end
          default: begin cosine_value <= s; sine_value <= -c; end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == TRIG_IDLE && go) begin
      quad <= angle[15:14];
      x <= signed'({2'b00, CORDIC_GAIN});
      y <= '0;
      z <= signed'({4'b0000, angle[13:0], 16'h0000});
      step <= '0;
    end else if (rotating) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atn;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atn;
      end
      step <= step + STEP_BITS'(1);
    end
  end
endmodule

>>> hdl/obb_front.sv
// Front end: accepts a query and forms its offset from the box center.
module obb_front #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  output logic                         push,
  output logic [4*COORD_BITS+1:0]      entry
);
  logic signed [COORD_BITS-1:0] qx, qy;
  logic signed [COORD_BITS:0] dx, dy;

  always_ff @(posedge clk) begin
    if (rst) push <= 1'b0;
    else push <= take;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      qx <= query_x;
      qy <= query_y;
      dx <= {query_x[COORD_BITS-1], query_x} - {center_x[COORD_BITS-1], center_x};
      dy <= {query_y[COORD_BITS-1], query_y} - {center_y[COORD_BITS-1], center_y};
    end
  end

  assign entry = {qx, qy, dx, dy};
endmodule

>>> hdl/obb_queue.sv
// Two-entry queue between front and back.
module obb_queue import obb_pkg::*; #(
  parameter int WIDTH = 130
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output obb_q_status_t    status
);
  localparam int PW = $clog2(QUEUE_DEPTH);
  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0] count;
  logic do_pop;

  assign do_pop = pop && !status.empty;
  assign status.empty = (count == '0);
  assign status.full = (count == (PW+1)'(QUEUE_DEPTH));
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (do_pop) rd_ptr <= rd_ptr + PW'(1);
      if (push && !do_pop) count <= count + (PW+1)'(1);
      else if (!push && do_pop) count <= count - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end
endmodule

>>> hdl/obb_back.sv
// Back end: projects, clamps and rebuilds the closest point in six stages.
module obb_back #(
  parameter int COORD_BITS = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [4*COORD_BITS+1:0]         entry,
  input  logic signed [FRACTION_BITS+1:0] cosine_value,
  input  logic signed [FRACTION_BITS+1:0] sine_value,
  input  logic signed [COORD_BITS-1:0]    center_x,
  input  logic signed [COORD_BITS-1:0]    center_y,
  input  logic [COORD_BITS-2:0]           half_width,
  input  logic [COORD_BITS-2:0]           half_height,
  output logic                            done,
  output logic signed [COORD_BITS-1:0]    near_x,
  output logic signed [COORD_BITS-1:0]    near_y,
  output logic                            is_inside
);
  localparam int CB = COORD_BITS;
  localparam int F = FRACTION_BITS;
  localparam int D = CB + 1;
  localparam int T = F + 2;
  localparam int P = D + T;
  localparam int SW = P + 1;
  localparam int LW = SW - F;
  localparam int M = CB + T;
  localparam int MW = M + 1;
  localparam int RW = MW - F;
  localparam int VW = RW + 1;
  localparam logic signed [SW-1:0] RND1 = SW'(1) << (F - 1);
  localparam logic signed [MW-1:0] RND2 = MW'(1) << (F - 1);
  localparam logic signed [VW-1:0] MAXV = VW'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [VW-1:0] MINV = -MAXV - VW'(1);

  logic signed [CB-1:0] e_qx, e_qy;
  logic signed [D-1:0] e_dx, e_dy;
  assign {e_qx, e_qy, e_dx, e_dy} = entry;

  logic v1, v2, v3, v4, v5;
  logic signed [CB-1:0] qx1, qy1, qx2, qy2, qx3, qy3, qx4, qy4, qx5, qy5;
  logic signed [P-1:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [LW-1:0] lx, ly, hw, hh;
  logic signed [CB-1:0] lxc, lyc;
  logic in3, in4, in5;
  logic signed [M-1:0] m_xc, m_ys, m_xs, m_yc;
  logic signed [MW-1:0] msum_x, msum_y;
  logic signed [RW-1:0] r_x, r_y;
  logic signed [VW-1:0] w_x, w_y;
  logic x_hi, x_lo, y_hi, y_lo;

  assign hw = signed'({{(LW-CB+1){1'b0}}, half_width});
  assign hh = signed'({{(LW-CB+1){1'b0}}, half_height});
  assign sum_x = SW'(p_xc) + SW'(p_ys) + RND1;
  assign sum_y = SW'(p_xs) - SW'(p_yc) + RND1;
  assign msum_x = MW'(m_xc) + MW'(m_ys) + RND2;
  assign msum_y = MW'(m_xs) - MW'(m_yc) + RND2;
  assign w_x = VW'(center_x) + VW'(r_x);
  assign w_y = VW'(center_y) + VW'(r_y);
  assign x_hi = lx > hw;
  assign x_lo = lx < -hw;
  assign y_hi = ly > hh;
  assign y_lo = ly < -hh;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      done <= v5;
    end
  end

  always_ff @(posedge clk) begin
    // multiply offsets by the box axes
    p_xc <= e_dx * cosine_value;
    p_ys <= e_dy * sine_value;
    p_xs <= e_dx * sine_value;
    p_yc <= e_dy * cosine_value;
    qx1 <= e_qx;
    qy1 <= e_qy;
    // round the projections
    lx <= sum_x[SW-1:F];
    ly <= sum_y[SW-1:F];
    qx2 <= qx1;
    qy2 <= qy1;
    // clamp to the half extents; equality counts as inside
    lxc <= x_hi ? hw[CB-1:0] : (x_lo ? -hw[CB-1:0] : lx[CB-1:0]);
    lyc <= y_hi ? hh[CB-1:0] : (y_lo ? -hh[CB-1:0] : ly[CB-1:0]);
    in3 <= !(x_hi || x_lo || y_hi || y_lo);
    qx3 <= qx2;
    qy3 <= qy2;
    // rotate the clamped point back to world axes
    m_xc <= lxc * cosine_value;
    m_ys <= lyc * sine_value;
    m_xs <= lxc * sine_value;
    m_yc <= lyc * cosine_value;
    in4 <= in3;
    qx4 <= qx3;
    qy4 <= qy3;
    r_x <= msum_x[MW-1:F];
    r_y <= msum_y[MW-1:F];
    in5 <= in4;
    qx5 <= qx4;
    qy5 <= qy4;
    // add the center and saturate, or pass the query through
    is_inside <= in5;
    if (in5) begin
      near_x <= qx5;
      near_y <= qy5;
    end else begin
      near_x <= (w_x > MAXV) ? MAXV[CB-1:0] : ((w_x < MINV) ? MINV[CB-1:0] : w_x[CB-1:0]);
      near_y <= (w_y > MAXV) ? MAXV[CB-1:0] : ((w_y < MINV) ? MINV[CB-1:0] : w_y[CB-1:0]);
    end
  end
endmodule

>>> hdl/obb_checker.sv
// Port-level checks for the closest point block, bound to the top level.
`include "obb_closest_point_assert.svh"
module obb_checker import obb_pkg::*; #(
  parameter int ADDR_BITS = 5
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic                 psel,
  input logic                 penable,
  input logic                 pwrite,
  input logic [ADDR_BITS-1:0] paddr
);
  localparam int AL = ADDR_BITS - 3;
  logic angle_wr;

  assign angle_wr = psel && penable && pwrite
                 && (obb_reg_t'(paddr[ADDR_BITS-1:AL]) == REG_BOX_ANGLE);

  // every transfer yields exactly one result
  `OBB_ASSERT_IMP(a_result_follows, clk, rst, $past(start && !busy, 8), done)
  `OBB_ASSERT_IMP(a_result_has_cause, clk, rst, done, $past(start && !busy, 8))
  // an angle write holds off queries while the trig runs
  `OBB_ASSERT_NXT(a_angle_busy, clk, rst, angle_wr && !busy, busy)
endmodule

bind obb_closest_point obb_checker #(.ADDR_BITS(ADDR_BITS)) u_obb_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr)
);
